@@ rtl/scmlerp_pkg.sv @@
// Shared types, register indexes and palette stops for the colormap pipeline.
// No dependencies; imported by sequential_colormap_lerp_top.
`default_nettype none

package scmlerp_pkg;

  // Palette geometry and fixed-point format
  localparam int unsigned NUM_STOPS = 5;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CFG_WIDTH = 32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RANGE_LOW      = 2'd0,
    REG_RANGE_HIGH     = 2'd1,
    REG_PALETTE_SELECT = 2'd2,
    REG_MISSING_RGBA   = 2'd3
  } cfg_reg_t;

  // Palette codes
  typedef enum logic [1:0] {
    PAL_VIRIDIS = 2'd0,
    PAL_CIVIDIS = 2'd1,
    PAL_PLASMA  = 2'd2,
    PAL_TURBO   = 2'd3
  } palette_t;

  // How the normalised position is produced for one item
  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,   // sample at or below the low end
    MODE_HIGH = 2'd1,   // sample at or above the high end
    MODE_DIV  = 2'd2    // strictly inside: quotient from the divider
  } norm_mode_t;

  typedef logic [2:0]      stop_idx_t;
  typedef logic [2:0][7:0] rgb_t;   // [2] red, [1] green, [0] blue

  // Stop colour lookup, {red, green, blue}
  function automatic rgb_t palette_color(input palette_t pal, input stop_idx_t stop);
    rgb_t c;
    c = '0;
    case ({pal, stop})
      {PAL_VIRIDIS, 3'd0}: c = {8'd68,  8'd1,   8'd84};
      {PAL_VIRIDIS, 3'd1}: c = {8'd59,  8'd82,  8'd139};
      {PAL_VIRIDIS, 3'd2}: c = {8'd33,  8'd145, 8'd140};
      {PAL_VIRIDIS, 3'd3}: c = {8'd94,  8'd201, 8'd98};
      {PAL_VIRIDIS, 3'd4}: c = {8'd253, 8'd231, 8'd37};
      {PAL_CIVIDIS, 3'd0}: c = {8'd0,   8'd34,  8'd78};
      {PAL_CIVIDIS, 3'd1}: c = {8'd66,  8'd64,  8'd134};
      {PAL_CIVIDIS, 3'd2}: c = {8'd122, 8'd123, 8'd120};
      {PAL_CIVIDIS, 3'd3}: c = {8'd188, 8'd174, 8'd108};
      {PAL_CIVIDIS, 3'd4}: c = {8'd254, 8'd232, 8'd56};
      {PAL_PLASMA,  3'd0}: c = {8'd13,  8'd8,   8'd135};
      {PAL_PLASMA,  3'd1}: c = {8'd126, 8'd3,   8'd168};
      {PAL_PLASMA,  3'd2}: c = {8'd204, 8'd71,  8'd120};
      {PAL_PLASMA,  3'd3}: c = {8'd248, 8'd148, 8'd65};
      {PAL_PLASMA,  3'd4}: c = {8'd240, 8'd249, 8'd33};
      {PAL_TURBO,   3'd0}: c = {8'd48,  8'd18,  8'd59};
      {PAL_TURBO,   3'd1}: c = {8'd70,  8'd107, 8'd227};
      {PAL_TURBO,   3'd2}: c = {8'd26,  8'd228, 8'd182};
      {PAL_TURBO,   3'd3}: c = {8'd249, 8'd231, 8'd33};
      {PAL_TURBO,   3'd4}: c = {8'd234, 8'd42,  8'd20};
      default:             c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sequential_colormap_lerp_top.sv @@
// Colormap pipeline top level: range normalisation, pipelined divider, stop blend.
// Depends on scmlerp_pkg (types, register indexes, palette table).
//
// Usage
//   in_*  : one signed Q16.16 sample per transfer on in_tdata, in_tuser = sample invalid.
//   out_* : one RGBA colour per transfer, red in the lowest byte of out_tdata.
//   cfg_* : register writes (range low/high, palette, missing colour); the user keeps them to idle, not enforced.
// Pipeline: 21 register stages (input register, range compare, 16 quotient stages,
//   stop lookup, multiply, round into the output register). out_tvalid is the valid
//   bit of the output register, and the colour transfers while out_tready is high.
// Throughput: one item per clock; the 16-stage restoring divider takes one quotient
//   bit per stage, so a new item enters every cycle while the output is not stalled.
// Stalls: every stage carries a valid bit and holds while the stage after it is full
//   and not moving; empty stages keep filling, so in_tready stays high until the
//   pipeline is completely full behind a stalled out_tready. Nothing is dropped.
// Reset (rst_n low, synchronous): all valid bits clear, registers return to range
//   0..1.0, viridis and a missing colour of zero.
`default_nettype none

module sequential_colormap_lerp_top #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // sample stream
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,  // [SW-1:0] sample
  input  wire                                   in_tuser,  // [0] sample_invalid
  // colour stream
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [31:0]                           out_tdata, // red, green, blue, alpha
  // configuration writes
  input  wire                                   cfg_we,
  input  wire [1:0]                             cfg_index,
  input  wire [scmlerp_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
  import scmlerp_pkg::*;

  localparam int unsigned EW        = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32;
  localparam int unsigned DIV_STEPS = FRAC_BITS;
  localparam int unsigned P_PREP    = 1;
  localparam int unsigned P_LUT     = P_PREP + DIV_STEPS + 1;
  localparam int unsigned P_MUL     = P_LUT + 1;
  localparam int unsigned P_OUT     = P_MUL + 1;
  localparam int unsigned NSTG      = P_OUT + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [31:0] range_low_r;
  logic signed [31:0] range_high_r;
  palette_t           palette_r;
  logic [31:0]        missing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= 32'sd0;
      range_high_r <= 32'sd65536;
      palette_r    <= PAL_VIRIDIS;
      missing_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RANGE_LOW:      range_low_r  <= cfg_wdata[31:0];
        REG_RANGE_HIGH:     range_high_r <= cfg_wdata[31:0];
        REG_PALETTE_SELECT: palette_r    <= palette_t'(cfg_wdata[1:0]);
        REG_MISSING_RGBA:   missing_r    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Effective range: an empty or inverted range falls back to 0..1.0
  logic signed [31:0] lo_eff;
  logic signed [31:0] hi_eff;

  always_comb begin
    if (range_high_r <= range_low_r) begin
      lo_eff = 32'sd0;
      hi_eff = 32'sd65536;
    end else begin
      lo_eff = range_low_r;
      hi_eff = range_high_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and per-stage advance
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[P_OUT];

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  logic signed [SAMPLE_WIDTH-1:0] samp_r;
  logic                           inv0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      samp_r <= in_tdata[SAMPLE_WIDTH-1:0];
      inv0_r <= in_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: compare against the range, form dividend and divisor
  logic signed [EW-1:0] s_ext;
  logic signed [EW-1:0] lo_ext;
  logic signed [EW-1:0] hi_ext;
  logic [EW-1:0]        diff_full;
  norm_mode_t           mode_nxt;

  always_comb begin
    s_ext     = EW'(samp_r);
    lo_ext    = EW'(lo_eff);
    hi_ext    = EW'(hi_eff);
    diff_full = s_ext - lo_ext;
    if (s_ext <= lo_ext) begin
      mode_nxt = MODE_LOW;
    end else if (s_ext >= hi_ext) begin
      mode_nxt = MODE_HIGH;
    end else begin
      mode_nxt = MODE_DIV;
    end
  end

  // divider chain: index 0 is the prepare stage, index j the j-th quotient stage
  logic [31:0]          rem_r  [DIV_STEPS+1];
  logic [31:0]          span_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_r  [DIV_STEPS+1];
  norm_mode_t           mode_r [DIV_STEPS+1];
  logic                 inv_r  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv[P_PREP]) begin
      // inside the range the difference is below the span, so 32 bits hold it
      rem_r[0]  <= diff_full[31:0];
      span_r[0] <= 32'(hi_eff - lo_eff);
      quo_r[0]  <= '0;
      mode_r[0] <= mode_nxt;
      inv_r[0]  <= inv0_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2..17: restoring division, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [32:0] trial;
    logic        take;
    logic [31:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[j-1], 1'b0};
      take    = trial >= {1'b0, span_r[j-1]};
      rem_nxt = take ? 32'(trial - {1'b0, span_r[j-1]}) : trial[31:0];
    end

    always_ff @(posedge clk) begin
      if (adv[P_PREP + j]) begin
        rem_r[j]  <= rem_nxt;
        span_r[j] <= span_r[j-1];
        quo_r[j]  <= {quo_r[j-1][DIV_STEPS-2:0], take};
        mode_r[j] <= mode_r[j-1];
        inv_r[j]  <= inv_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 18: position, stop selection and palette lookup
  logic [FRAC_BITS:0]   norm;
  stop_idx_t            left_stop;
  stop_idx_t            right_stop;
  logic [FRAC_BITS-1:0] frac_nxt;
  rgb_t                 col_a;
  rgb_t                 col_b;

  always_comb begin
    case (mode_r[DIV_STEPS])
      MODE_LOW:  norm = '0;
      MODE_HIGH: norm = {1'b1, {FRAC_BITS{1'b0}}};
      MODE_DIV:  norm = {1'b0, quo_r[DIV_STEPS]};
      default:   norm = '0;
    endcase
    // position times four: top bits pick the stop, the rest is the blend fraction
    left_stop  = norm[FRAC_BITS:FRAC_BITS-2];
    right_stop = (left_stop == stop_idx_t'(NUM_STOPS - 1)) ? left_stop
                                                           : left_stop + 3'd1;
    frac_nxt   = {norm[FRAC_BITS-3:0], 2'b00};
    col_a      = palette_color(palette_r, left_stop);
    col_b      = palette_color(palette_r, right_stop);
  end

  logic [2:0][7:0]         base_r;
  logic signed [2:0][8:0]  delta_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic                    inv_lut_r;

  always_ff @(posedge clk) begin
    if (adv[P_LUT]) begin
      for (int c = 0; c < 3; c++) begin
        base_r[c]  <= col_a[c];
        delta_r[c] <= $signed({1'b0, col_b[c]}) - $signed({1'b0, col_a[c]});
      end
      frac_r    <= frac_nxt;
      inv_lut_r <= inv_r[DIV_STEPS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 19: fraction times stop difference per channel
  logic [2:0][7:0]          base_m_r;
  logic signed [2:0][25:0]  prod_r;
  logic                     inv_mul_r;

  always_ff @(posedge clk) begin
    if (adv[P_MUL]) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= 26'($signed({1'b0, frac_r}) * $signed(delta_r[c]));
      end
      base_m_r  <= base_r;
      inv_mul_r <= inv_lut_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 20: add base, round half to even, output register
  logic [2:0][25:0] num;
  logic [2:0][7:0]  chan;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = {2'b00, base_m_r[c], {FRAC_BITS{1'b0}}} + prod_r[c];
      // the blend lies between the two stops, so no carry past 8 bits
      if ((num[c][15:0] > 16'h8000) || (num[c][15:0] == 16'h8000 && num[c][16])) begin
        chan[c] = num[c][23:16] + 8'd1;
      end else begin
        chan[c] = num[c][23:16];
      end
    end
  end

  logic [31:0] rgba_r;

  always_ff @(posedge clk) begin
    if (adv[P_OUT]) begin
      if (inv_mul_r) begin
        rgba_r <= {missing_r[7:0], missing_r[15:8], missing_r[23:16], missing_r[31:24]};
      end else begin
        rgba_r <= {ALPHA_OPAQUE, chan[0], chan[1], chan[2]};
      end
    end
  end

  assign out_tdata = rgba_r;

endmodule

`default_nettype wire
